// File: design/scr_pkg.sv
package scr_pkg;

    // Fixed-point precision of linear light and of the output ratio.
    localparam int LUMA_FRAC_BITS  = 16;
    localparam int RATIO_FRAC_BITS = 8;

    localparam int COLOR_W   = 24;
    localparam int CHANNEL_W = 8;
    localparam int LIN_W     = LUMA_FRAC_BITS + 1;
    localparam int LUM_W     = LUMA_FRAC_BITS + 1;

    // Luminance weights in units of 1/10000, and the half-up rounding term.
    localparam int WEIGHT_W = 14;
    localparam logic [WEIGHT_W-1:0] WEIGHT_R  = WEIGHT_W'(2126);
    localparam logic [WEIGHT_W-1:0] WEIGHT_G  = WEIGHT_W'(7152);
    localparam logic [WEIGHT_W-1:0] WEIGHT_B  = WEIGHT_W'(722);
    localparam logic [WEIGHT_W-1:0] LUM_ROUND = WEIGHT_W'(5000);

    // Width of the weighted sum before the divide by 10000.
    localparam longint unsigned LUM_SUM_MAX =
        64'd10000 * (64'd1 << LUMA_FRAC_BITS) + 64'd5000;
    localparam int LUM_SUM_W = $clog2(LUM_SUM_MAX + 64'd1);

    // Reciprocal of 10000. The rounding error of the ceiling is below 2^14,
    // so the quotient is exact for every sum below 2^LUM_SUM_W.
    localparam int RECIP_SHIFT = LUM_SUM_W + 14;
    localparam longint unsigned RECIP_MUL =
        ((64'd1 << RECIP_SHIFT) + 64'd9999) / 64'd10000;
    localparam int RECIP_W = $clog2(RECIP_MUL + 64'd1);
    localparam int PROD_W  = LUM_SUM_W + RECIP_W;

    // Divider operand widths.
    localparam longint unsigned DEN_MAX = 64'd21 << LUMA_FRAC_BITS;
    localparam int DEN_W = $clog2(DEN_MAX + 64'd1);
    localparam longint unsigned NUM_MAX =
        (64'd21 << (LUMA_FRAC_BITS + RATIO_FRAC_BITS)) + (DEN_MAX >> 1);
    localparam int NUM_W  = $clog2(NUM_MAX + 64'd1);
    localparam int QUOT_W = RATIO_FRAC_BITS + 5;
    localparam int CMP_W  = DEN_W + QUOT_W;

    localparam logic [QUOT_W-1:0] RATIO_MIN = QUOT_W'(64'd1 << RATIO_FRAC_BITS);
    localparam logic [QUOT_W-1:0] RATIO_MAX = QUOT_W'(64'd21 << RATIO_FRAC_BITS);

    localparam longint unsigned Q31_ONE = 64'd1 << 31;

    typedef logic [LIN_W-1:0] lin_table_t [256];

    // Fifth power of a Q0.31 value, truncating after each product.
    function automatic longint unsigned pow5_q31(input longint unsigned y);
        longint unsigned y2;
        longint unsigned y4;
        y2 = (y * y) >> 31;
        y4 = (y2 * y2) >> 31;
        return (y4 * y) >> 31;
    endfunction

    // Linear light of each 8-bit sRGB code, in Q1.LUMA_FRAC_BITS.
    function automatic lin_table_t build_lin_table();
        lin_table_t      tbl;
        longint unsigned k;
        longint unsigned u;
        longint unsigned u2;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        longint unsigned v;
        for (int idx = 0; idx < 256; idx++)
        begin
            k = longint'(idx);
            if (k <= 64'd10)
            begin
                tbl[idx] = LIN_W'(((64'd10 * k << LUMA_FRAC_BITS) + 64'd16473) / 64'd32946);
            end
            else
            begin
                u = (((64'd1000 * k + 64'd14025) << 31) + 64'd134512) / 64'd269025;
                if (u > Q31_ONE)
                begin
                    u = Q31_ONE;
                end
                u2 = (u * u) >> 31;
                // Bisection for the fifth root of u^2.
                lo = 64'd0;
                hi = Q31_ONE;
                for (int it = 0; it < 34; it++)
                begin
                    if (lo < hi)
                    begin
                        mid = (lo + hi + 64'd1) >> 1;
                        if (pow5_q31(mid) <= u2)
                        begin
                            lo = mid;
                        end
                        else
                        begin
                            hi = mid - 64'd1;
                        end
                    end
                end
                v = (u2 * lo) >> 31;
                tbl[idx] = LIN_W'(((v << LUMA_FRAC_BITS) + (64'd1 << 30)) >> 31);
            end
        end
        return tbl;
    endfunction

    localparam lin_table_t LIN_TABLE = build_lin_table();

endpackage

// File: design/srgb_contrast_ratio.sv
// WCAG 2 contrast ratio of two packed sRGB colors, rounded to Q5.8.
// An item passes 18 register stages from input accept to the output register: four luminance
// stages, one divider stage per quotient bit and the output register; the first stage loads
// at the accept edge. Throughput: one item per cycle while the skid register is empty;
// the 13-stage restoring divider is fully pipelined.
// Reset clears all valid bits, including those of the output and skid registers.
module srgb_contrast_ratio (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [scr_pkg::COLOR_W-1:0]   color_first,
    input  logic [scr_pkg::COLOR_W-1:0]   color_second,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [scr_pkg::QUOT_W-1:0]    ratio_q8
);
    import scr_pkg::*;

    logic advance;
    logic in_take;

    // The pipeline moves unless the skid register holds a result.
    logic skid_valid_reg;
    assign advance  = !skid_valid_reg;
    assign in_stall = skid_valid_reg;
    assign in_take  = in_valid && advance;

    // Stage 1: table lookup of all six channels.
    logic             s1_valid_reg;
    logic [LIN_W-1:0] lin_a_reg [3];
    logic [LIN_W-1:0] lin_b_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= in_take;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            lin_a_reg[0] <= LIN_TABLE[color_first[23:16]];
            lin_a_reg[1] <= LIN_TABLE[color_first[15:8]];
            lin_a_reg[2] <= LIN_TABLE[color_first[7:0]];
            lin_b_reg[0] <= LIN_TABLE[color_second[23:16]];
            lin_b_reg[1] <= LIN_TABLE[color_second[15:8]];
            lin_b_reg[2] <= LIN_TABLE[color_second[7:0]];
        end
    end

    // Stage 2: weighted sum of the channels with the rounding term.
    logic                 s2_valid_reg;
    logic [LUM_SUM_W-1:0] sum_a_reg;
    logic [LUM_SUM_W-1:0] sum_b_reg;
    logic [LUM_SUM_W-1:0] sum_a_next;
    logic [LUM_SUM_W-1:0] sum_b_next;

    assign sum_a_next = LUM_SUM_W'(lin_a_reg[0]) * LUM_SUM_W'(WEIGHT_R)
                      + LUM_SUM_W'(lin_a_reg[1]) * LUM_SUM_W'(WEIGHT_G)
                      + LUM_SUM_W'(lin_a_reg[2]) * LUM_SUM_W'(WEIGHT_B)
                      + LUM_SUM_W'(LUM_ROUND);
    assign sum_b_next = LUM_SUM_W'(lin_b_reg[0]) * LUM_SUM_W'(WEIGHT_R)
                      + LUM_SUM_W'(lin_b_reg[1]) * LUM_SUM_W'(WEIGHT_G)
                      + LUM_SUM_W'(lin_b_reg[2]) * LUM_SUM_W'(WEIGHT_B)
                      + LUM_SUM_W'(LUM_ROUND);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sum_a_reg <= sum_a_next;
            sum_b_reg <= sum_b_next;
        end
    end

    // Stage 3: divide by 10000 through the reciprocal product.
    logic              s3_valid_reg;
    logic [PROD_W-1:0] prod_a_reg;
    logic [PROD_W-1:0] prod_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            prod_a_reg <= PROD_W'(sum_a_reg) * PROD_W'(RECIP_MUL);
            prod_b_reg <= PROD_W'(sum_b_reg) * PROD_W'(RECIP_MUL);
        end
    end

    // Stage 4: order the luminances and form the rounded dividend and the divisor.
    logic             s4_valid_reg;
    logic [NUM_W-1:0] num_reg;
    logic [DEN_W-1:0] den_reg;
    logic [LUM_W-1:0] lum_a;
    logic [LUM_W-1:0] lum_b;
    logic [LUM_W-1:0] lum_hi;
    logic [LUM_W-1:0] lum_lo;
    logic [DEN_W-1:0] den_next;
    logic [DEN_W-1:0] top_scaled;
    logic [NUM_W-1:0] num_next;

    assign lum_a      = LUM_W'(prod_a_reg >> RECIP_SHIFT);
    assign lum_b      = LUM_W'(prod_b_reg >> RECIP_SHIFT);
    assign lum_hi     = (lum_a > lum_b) ? lum_a : lum_b;
    assign lum_lo     = (lum_a > lum_b) ? lum_b : lum_a;
    assign den_next   = DEN_W'(lum_lo) * DEN_W'(20) + (DEN_W'(1) << LUMA_FRAC_BITS);
    assign top_scaled = DEN_W'(lum_hi) * DEN_W'(20) + (DEN_W'(1) << LUMA_FRAC_BITS);
    assign num_next   = (NUM_W'(top_scaled) << RATIO_FRAC_BITS) + NUM_W'(den_next >> 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            num_reg <= num_next;
            den_reg <= den_next;
        end
    end

    // Pipelined division of the ratio.
    logic              div_valid;
    logic [QUOT_W-1:0] div_quot;

    scr_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (advance),
        .in_valid  (s4_valid_reg),
        .in_num    (num_reg),
        .in_den    (den_reg),
        .out_valid (div_valid),
        .out_quot  (div_quot)
    );

    // Clamp to the legal ratio range.
    logic [QUOT_W-1:0] ratio_clamped;

    always_comb
    begin
        ratio_clamped = div_quot;
        if (div_quot < RATIO_MIN)
        begin
            ratio_clamped = RATIO_MIN;
        end
        else if (div_quot > RATIO_MAX)
        begin
            ratio_clamped = RATIO_MAX;
        end
    end

    // Output register with a skid register behind it.
    logic              out_valid_reg;
    logic [QUOT_W-1:0] out_data_reg;
    logic [QUOT_W-1:0] skid_data_reg;
    logic              out_take;
    logic              arrive;
    logic              out_free;

    assign out_take = out_valid_reg && !out_stall;
    assign arrive   = div_valid && advance;
    assign out_free = !out_valid_reg || out_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= arrive;
            end
        end
        else if (arrive)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_data_reg <= skid_data_reg;
            end
            else
            begin
                out_data_reg <= ratio_clamped;
            end
        end
        else if (arrive)
        begin
            skid_data_reg <= ratio_clamped;
        end
    end

    assign out_valid = out_valid_reg;
    assign ratio_q8  = out_data_reg;

endmodule

// File: design/scr_divider.sv
module scr_divider (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [scr_pkg::NUM_W-1:0]   in_num,
    input  logic [scr_pkg::DEN_W-1:0]   in_den,
    output logic                        out_valid,
    output logic [scr_pkg::QUOT_W-1:0]  out_quot
);
    import scr_pkg::*;

    // One quotient bit per stage, most significant bit first.
    logic [QUOT_W-1:0] valid_reg;
    logic [NUM_W-1:0]  rem_reg  [QUOT_W];
    logic [DEN_W-1:0]  den_reg  [QUOT_W];
    logic [QUOT_W-1:0] quot_reg [QUOT_W];

    for (genvar i = 0; i < QUOT_W; i++)
    begin : g_stage
        localparam int BIT_POS = QUOT_W - 1 - i;

        logic              valid_in;
        logic [NUM_W-1:0]  rem_in;
        logic [DEN_W-1:0]  den_in;
        logic [QUOT_W-1:0] quot_in;
        logic [CMP_W-1:0]  den_shifted;
        logic [CMP_W-1:0]  rem_wide;
        logic              fits;
        logic [NUM_W-1:0]  rem_next;
        logic [QUOT_W-1:0] quot_next;

        // Operands come from the port for the first stage, else from the stage before.
        if (i == 0)
        begin : g_first
            assign valid_in = in_valid;
            assign rem_in   = in_num;
            assign den_in   = in_den;
            assign quot_in  = '0;
        end
        else
        begin : g_rest
            assign valid_in = valid_reg[i-1];
            assign rem_in   = rem_reg[i-1];
            assign den_in   = den_reg[i-1];
            assign quot_in  = quot_reg[i-1];
        end

        // Trial subtraction of the shifted divisor.
        assign den_shifted = CMP_W'(den_in) << BIT_POS;
        assign rem_wide    = CMP_W'(rem_in);
        assign fits        = rem_wide >= den_shifted;

        always_comb
        begin
            rem_next  = rem_in;
            quot_next = quot_in;
            if (fits)
            begin
                rem_next           = NUM_W'(rem_wide - den_shifted);
                quot_next[BIT_POS] = 1'b1;
            end
        end

        // Valid bit of this stage.
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[i] <= valid_in;
            end
        end

        // Operands of this stage.
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]  <= rem_next;
                den_reg[i]  <= den_in;
                quot_reg[i] <= quot_next;
            end
        end
    end

    assign out_valid = valid_reg[QUOT_W-1];
    assign out_quot  = quot_reg[QUOT_W-1];

endmodule
